### design/cross_neighbor_peak_clip_defines.svh
// Assertion macros for the cross-neighbour peak clipper.
// Included by the top level; the assertions collapse to nothing under SYNTHESIS.
`ifndef CROSS_NEIGHBOR_PEAK_CLIP_DEFINES_SVH
`define CROSS_NEIGHBOR_PEAK_CLIP_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent holds, so the consequent holds in the same cycle.
`define CNPC_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cnpc assertion failed");
// Antecedent holds, so the consequent holds in the next cycle.
`define CNPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cnpc assertion failed");
`else
`define CNPC_ASSERT(label, clk, rst_n, ante, cons)
`define CNPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/cnpc_pkg.sv
// Shared types and constants for the cross-neighbour peak clipper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cnpc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 16;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WCNT_W     = COL_W + 1;
	localparam int WIDTH_BITS = 11;
	localparam int ROW_W      = 16;
	localparam int ADDR_W     = 3;
	localparam int NUM_CELLS  = 2;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	// One column of the window: the two most recent rows at that column.
	typedef struct packed {
		pix_t above;
		pix_t center;
	} col_t;

	// Register map, selected by paddr[2].
	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// Decoded effect of one input transfer.
	typedef struct packed {
		logic             adv;
		logic             emit;
		logic             wr;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] nxt;
		logic             has_up;
		logic             has_left;
		logic             has_right;
		logic             has_below;
		logic             row_end;
		logic             frame_end;
	} ev_t;

endpackage

### design/cnpc_ram.sv
// Line buffer for the peak clipper: one write and one registered read per cycle.
// Depends on cnpc_pkg for the depth and the column type.
`timescale 1ns / 1ps
module cnpc_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [cnpc_pkg::COL_W-1:0] wr_addr,
	input  cnpc_pkg::col_t             wr_data,
	input  logic                       rd_en,
	input  logic [cnpc_pkg::COL_W-1:0] rd_addr,
	output cnpc_pkg::col_t             rd_data
);
	import cnpc_pkg::*;

	col_t mem [MAX_WIDTH];
	col_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/cnpc_cell.sv
// Window cell: holds one column of the neighbourhood and hands it on when the window advances.
// Depends on cnpc_pkg for the column type.
`timescale 1ns / 1ps
module cnpc_cell (
	input  logic           clk,
	input  logic           adv,
	input  cnpc_pkg::col_t d,
	output cnpc_pkg::col_t q
);
	import cnpc_pkg::*;

	col_t col_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			col_q <= d;
		end
	end

	assign q = col_q;

endmodule

### design/cnpc_seq.sv
// Raster sequencer: input and output position counters and per-transfer decode.
// Depends on cnpc_pkg for the event struct and counter widths.
`timescale 1ns / 1ps
module cnpc_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_clear,
	input  logic [cnpc_pkg::WIDTH_BITS-1:0] image_width,
	input  logic [cnpc_pkg::ROW_W-1:0]      image_height,
	input  logic                            s_acc,
	input  logic                            req_drain,
	output cnpc_pkg::ev_t                   ev
);
	import cnpc_pkg::*;

	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [WCNT_W-1:0] w_eff, w_last;
	logic [ROW_W-1:0]  h_eff;
	logic              in_last, out_last, in_done, out_row_last, drain_row;
	logic              pix_eff, drn_eff;
	logic [COL_W-1:0]  col;

	always_comb begin
		if (image_width == '0) begin
			w_eff = WCNT_W'(1);
		end else if (32'(image_width) > MAX_WIDTH) begin
			w_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			w_eff = WCNT_W'(image_width);
		end
	end

	assign w_last = w_eff - WCNT_W'(1);
	assign h_eff  = (image_height == '0) ? ROW_W'(1) : image_height;

	assign in_last      = ({1'b0, in_col_q} == w_last);
	assign out_last     = ({1'b0, out_col_q} == w_last);
	assign in_done      = (in_row_q >= h_eff);
	assign out_row_last = ((ROW_W+1)'(out_row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);
	assign drain_row    = ((ROW_W+1)'(out_row_q) + (ROW_W+1)'(1)) == (ROW_W+1)'(h_eff);

	// Surplus pixels and early drain ticks are taken and dropped.
	assign pix_eff = !req_drain && !in_done;
	assign drn_eff = req_drain && in_done && drain_row;
	assign col     = req_drain ? out_col_q : in_col_q;

	always_comb begin
		ev.adv       = pix_eff || drn_eff;
		ev.emit      = (pix_eff && (in_row_q != '0)) || drn_eff;
		ev.wr        = pix_eff;
		ev.col       = col;
		ev.nxt       = (req_drain ? out_last : in_last) ? '0 : col + COL_W'(1);
		ev.has_up    = (out_row_q != '0);
		ev.has_left  = (out_col_q != '0);
		ev.has_right = !out_last;
		ev.has_below = !req_drain;
		ev.row_end   = out_last;
		ev.frame_end = out_last && out_row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_clear || (s_acc && drn_eff && ev.frame_end)) begin
			// drop the frame in progress, or start afresh after the last pixel
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (s_acc) begin
			if (pix_eff) begin
				if (in_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (ev.emit) begin
				if (out_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

### design/cross_neighbor_peak_clip.sv
// Top level of the cross-neighbour peak clipper: stream ports, register port, window and clip.
// Depends on cnpc_pkg, cnpc_ram, cnpc_cell, cnpc_seq and the assertion macro header.
`timescale 1ns / 1ps
`include "cross_neighbor_peak_clip_defines.svh"

// Four-neighbour peak clipper. Pixels arrive in raster order on the slave stream
// (tuser low); every pixel strictly above all its existing up, down, left and right
// neighbours leaves at the level of the largest of them. Results trail the input by
// one row: the pixel above is sent when the pixel below arrives, and after the frame
// the last row is pushed out by drain transfers (tuser high), one pixel each. The block
// takes one transfer per clock while the master stream is not stalled; a result is
// registered in stage 1 and then in the output register before it reaches the master
// stream. The block has a single line buffer memory, which gives one read and one
// write per cycle, and a window of column cells that advances once per pixel. The line
// buffer needs no clearing after reset. Writing image_width or image_height abandons
// any frame in progress; write them only while the block is idle.
module cross_neighbor_peak_clip (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cnpc_pkg::PIXEL_BITS-1:0] s_tdata,  // [15:0] pixel_in
	input  logic                            s_tuser,  // [0] req_type (1 = drain)
	// master stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cnpc_pkg::PIXEL_BITS-1:0] m_tdata,  // [15:0] pixel_out
	output logic                            m_tlast,  // row_end
	output logic                            m_tuser,  // [0] frame_end
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cnpc_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import cnpc_pkg::*;

	logic [WIDTH_BITS-1:0] image_width_q;
	logic [ROW_W-1:0]      image_height_q;
	logic                  cfg_wr;
	logic                  s_acc, adv;
	ev_t                   ev, ev_s1;
	col_t                  ram_q, head, wr_col, fwd_data_q;
	logic                  fwd_q;
	col_t                  cell_d [NUM_CELLS];
	col_t                  cell_q [NUM_CELLS];
	logic                  valid_s1;
	pix_t                  below_s1;
	logic                  out_take;
	logic                  out_valid_q, out_row_end_q, out_frame_end_q;
	pix_t                  out_pix_q;
	pix_t                  mx, cand, clip_pix;
	logic                  any;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_BITS'(1);
			image_height_q <= ROW_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_WIDTH: begin
					image_width_q <= pwdata[WIDTH_BITS-1:0];
				end
				REG_HEIGHT: begin
					image_height_q <= pwdata[ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_WIDTH:  prdata = 32'(image_width_q);
			REG_HEIGHT: prdata = 32'(image_height_q);
			default:    prdata = '0;
		endcase
	end

	// input side
	assign s_tready = !valid_s1 || !out_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign adv      = s_acc && ev.adv;

	cnpc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_clear   (cfg_wr),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.s_acc       (s_acc),
		.req_drain   (s_tuser),
		.ev          (ev)
	);

	// Head of the window: the column after the current one, read one transfer ahead.
	assign head   = fwd_q ? fwd_data_q : ram_q;
	assign wr_col = '{above: head.center, center: s_tdata};

	cnpc_ram u_ram (
		.clk    (clk),
		.wr_en  (adv && ev.wr),
		.wr_addr(ev.col),
		.wr_data(wr_col),
		.rd_en  (adv),
		.rd_addr(ev.nxt),
		.rd_data(ram_q)
	);

	// a one-pixel row reads back the column it is writing: bypass the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (adv) begin
			fwd_q <= ev.wr && (ev.nxt == ev.col);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_data_q <= wr_col;
		end
	end

	// window chain: head -> centre column -> left column
	assign cell_d[0] = head;

	for (genvar i = 1; i < NUM_CELLS; i++) begin : g_link
		assign cell_d[i] = cell_q[i-1];
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		cnpc_cell u_cell (
			.clk(clk),
			.adv(adv),
			.d  (cell_d[i]),
			.q  (cell_q[i])
		);
	end

	// stage 1: window settled, clip
	assign out_take = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= ev.emit;
		end else if (out_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_s1    <= ev;
			below_s1 <= s_tdata;
		end
	end

	always_comb begin
		mx   = '0;
		any  = 1'b0;
		cand = '0;
		if (ev_s1.has_up) begin
			mx  = cell_q[0].above;
			any = 1'b1;
		end
		if (ev_s1.has_left) begin
			cand = cell_q[1].center;
			if (!any || cand > mx) begin
				mx = cand;
			end
			any = 1'b1;
		end
		if (ev_s1.has_right) begin
			cand = head.center;
			if (!any || cand > mx) begin
				mx = cand;
			end
			any = 1'b1;
		end
		if (ev_s1.has_below) begin
			cand = below_s1;
			if (!any || cand > mx) begin
				mx = cand;
			end
			any = 1'b1;
		end
		clip_pix = (any && mx < cell_q[0].center) ? mx : cell_q[0].center;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && valid_s1) begin
			out_pix_q       <= clip_pix;
			out_row_end_q   <= ev_s1.row_end;
			out_frame_end_q <= ev_s1.frame_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_row_end_q;
	assign m_tuser  = out_frame_end_q;

	// checks
	`CNPC_ASSERT(a_frame_end_on_row_end, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	`CNPC_ASSERT(a_hold_when_full, clk, arst_n, valid_s1 && out_valid_q && !m_tready, !s_tready)
	`CNPC_ASSERT(a_bypass_narrow, clk, arst_n, adv && ev.wr && (ev.nxt == ev.col), image_width_q <= WIDTH_BITS'(1))
	`CNPC_ASSERT_NEXT(a_window_holds, clk, arst_n, valid_s1 && out_valid_q && !m_tready, $stable(head))

endmodule
